@@ src/osts_pkg.sv @@
// Shared types and constants for the one-shot timer slot table.
`default_nettype none

package osts_pkg;

    // Default number of timer slots
    localparam int SLOT_COUNT_DEF = 16;

    // Field widths
    localparam int TIME_W = 24;
    localparam int TAG_W  = 16;
    localparam int MASK_W = 16;
    localparam int SIDX_W = 4;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Operation codes
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Input item
    typedef struct packed {
        logic [1:0]        op;
        logic [TIME_W-1:0] duration;
        logic [TAG_W-1:0]  payload_tag;
        logic [TIME_W-1:0] elapsed;
    } cmd_t;

    // Result item
    typedef struct packed {
        logic              accepted;
        logic [SIDX_W-1:0] slot_index;
        logic [MASK_W-1:0] active_mask;
        logic [MASK_W-1:0] expired_mask;
    } result_t;

    // One memory word per slot
    typedef struct packed {
        logic [TIME_W-1:0] duration;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] elapsed;
    } slot_word_t;

    // Outcome of advancing one slot
    typedef struct packed {
        slot_word_t word;
        logic       expired;
    } tick_update_t;

endpackage

`default_nettype wire

@@ src/osts_tick_unit.sv @@
// Advance one slot by a time step: saturating add and expiry compare.
`default_nettype none

module osts_tick_unit (
    input  osts_pkg::slot_word_t   word,
    input  logic [23:0]            step,
    output osts_pkg::tick_update_t upd
);
    import osts_pkg::*;

    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] sat;

    // Add with a carry bit, clamp at the top of the range
    assign sum = {1'b0, word.elapsed} + {1'b0, step};
    assign sat = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

    // Write back the new elapsed time, keep duration and tag
    always_comb
    begin
        upd.word.duration = word.duration;
        upd.word.tag      = word.tag;
        upd.word.elapsed  = sat;
        upd.expired       = (sat >= word.duration);
    end

endmodule

`default_nettype wire

@@ src/one_shot_timer_slot_table.sv @@
// Top level of the one-shot timer slot table.
`default_nettype none

// One item is taken when start is high and busy is low; its result shows on
// result for exactly one cycle with done high, and cannot be held off. A
// tick walks every slot through the single read port of the slot memory. A
// push scans the active bits one slot a cycle until it claims a free slot
// or finds the table full. Clear-all and the unused op code go straight to
// the report step. Duration, tag and elapsed time of each slot live in one
// memory with a registered read; active bits are flip-flops that reset
// clears, so no clearing pass is needed after reset.
module one_shot_timer_slot_table #(
    parameter int SLOT_COUNT = osts_pkg::SLOT_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  osts_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done,
    output osts_pkg::result_t result
);
    import osts_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SHOWN = (SLOT_COUNT < MASK_W) ? SLOT_COUNT : MASK_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_TICK   = 4'b0100,
        S_REPORT = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [SLOT_COUNT-1:0] active_reg, active_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              issue_done_reg, issue_done_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              accepted_reg, accepted_next;
    logic [SIDX_W-1:0] index_reg, index_next;
    logic [MASK_W-1:0] expired_reg, expired_next;
    logic              done_reg, done_next;
    result_t           result_reg, result_next;
    logic [MASK_W-1:0] shown_mask;

    // Slot memory ports
    slot_word_t        mem [SLOT_COUNT];
    slot_word_t        rd_data_reg;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    slot_word_t        wr_data;
    tick_update_t      upd;

    // Advance the slot just read
    osts_tick_unit u_tick (
        .word (rd_data_reg),
        .step (cmd_reg.elapsed),
        .upd  (upd)
    );

    // Low slots as seen on the mask outputs
    always_comb
    begin
        shown_mask = '0;
        shown_mask[SHOWN-1:0] = active_reg[SHOWN-1:0];
    end

    // Sequence one item: scan for a free slot, walk the table on a tick, or clear all
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        active_next     = active_reg;
        idx_next        = idx_reg;
        issue_done_next = issue_done_reg;
        rd_valid_next   = 1'b0;
        rd_idx_next     = rd_idx_reg;
        accepted_next   = accepted_reg;
        index_next      = index_reg;
        expired_next    = expired_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = upd.word;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next        = cmd;
                    idx_next        = '0;
                    issue_done_next = 1'b0;
                    accepted_next   = 1'b0;
                    index_next      = '0;
                    expired_next    = '0;
                    case (cmd.op)
                        OP_PUSH:  state_next = S_SCAN;
                        OP_TICK:  state_next = S_TICK;
                        OP_CLEAR:
                        begin
                            active_next = '0;
                            state_next  = S_REPORT;
                        end
                        default:  state_next = S_REPORT;
                    endcase
                end
            end

            S_SCAN:
            begin
                if (!active_reg[idx_reg])
                begin
                    // Claim this slot: store duration and tag, zero elapsed
                    wr_en                = 1'b1;
                    wr_addr              = idx_reg;
                    wr_data.duration     = cmd_reg.duration;
                    wr_data.tag          = cmd_reg.payload_tag;
                    wr_data.elapsed      = '0;
                    active_next[idx_reg] = 1'b1;
                    accepted_next        = 1'b1;
                    index_next           = SIDX_W'(idx_reg);
                    state_next           = S_REPORT;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = S_REPORT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_TICK:
            begin
                // Issue one read a cycle
                if (!issue_done_reg)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = idx_reg;
                    rd_valid_next = 1'b1;
                    rd_idx_next   = idx_reg;
                    if (idx_reg == LAST_IDX)
                        issue_done_next = 1'b1;
                    else
                        idx_next = idx_reg + 1'b1;
                end
                // Write back the slot read last cycle; drop it when it expires
                if (rd_valid_reg && active_reg[rd_idx_reg])
                begin
                    wr_en   = 1'b1;
                    wr_addr = rd_idx_reg;
                    wr_data = upd.word;
                    if (upd.expired)
                    begin
                        active_next[rd_idx_reg] = 1'b0;
                        if (int'(rd_idx_reg) < MASK_W)
                            expired_next[SIDX_W'(rd_idx_reg)] = 1'b1;
                    end
                end
                if (rd_valid_reg && rd_idx_reg == LAST_IDX)
                    state_next = S_REPORT;
            end

            S_REPORT:
            begin
                result_next.accepted     = accepted_reg;
                result_next.slot_index   = index_reg;
                result_next.active_mask  = shown_mask;
                result_next.expired_mask = expired_reg;
                done_next                = 1'b1;
                state_next               = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            active_reg     <= '0;
            idx_reg        <= '0;
            issue_done_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            idx_reg        <= idx_next;
            issue_done_reg <= issue_done_next;
            rd_valid_reg   <= rd_valid_next;
            done_reg       <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        rd_idx_reg   <= rd_idx_next;
        accepted_reg <= accepted_next;
        index_reg    <= index_next;
        expired_reg  <= expired_next;
        result_reg   <= result_next;
    end

    // Slot memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // A taken item makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item taken but block not busy");

    // A result follows the report step only
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_REPORT))
        else $error("result strobe outside report");

    // Read data is only in flight during a tick walk
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == S_TICK))
        else $error("slot read outside tick walk");

    // An expired slot is no longer active
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.expired_mask & result.active_mask) == '0))
        else $error("slot both expired and active");

endmodule

`default_nettype wire

@@ tb/sv/tb_one_shot_timer_slot_table.sv @@
// Self-checking bench for the one-shot timer slot table: command stream in, predicted masks out.
`timescale 1ns / 100ps

module tb_one_shot_timer_slot_table;

    import osts_pkg::*;

    localparam int SLOTS = SLOT_COUNT_DEF;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1800;
    localparam int DRAIN_CYCLES = SLOTS + 8;

    logic    clk;
    logic    rst_n;
    logic    start = 1'b0;
    cmd_t    cmd = '0;
    logic    busy;
    logic    done;
    result_t result;

    // Shadow copy of the slot table
    bit              slot_live  [SLOTS];
    bit [TIME_W-1:0] slot_age   [SLOTS];
    bit [TIME_W-1:0] slot_life  [SLOTS];
    bit [TAG_W-1:0]  slot_label [SLOTS];

    cmd_t    pending_cmds[$];
    result_t expected_results[$];
    int      error_count = 0;
    int      items_issued = 0;

    one_shot_timer_slot_table dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    // Advance the shadow table by one item and return the result it should give
    function automatic result_t timer_table_step(cmd_t c);
        result_t         r;
        bit              claimed;
        bit [TIME_W:0]   sum;
        r = '0;
        claimed = 1'b0;
        case (c.op)
            OP_PUSH:
                for (int i = 0; i < SLOTS; i++) begin
                    if (!claimed && !slot_live[i]) begin
                        claimed       = 1'b1;
                        slot_live[i]  = 1'b1;
                        slot_age[i]   = '0;
                        slot_life[i]  = c.duration;
                        slot_label[i] = c.payload_tag;
                        r.accepted    = 1'b1;
                        r.slot_index  = SIDX_W'(i);
                    end
                end
            OP_CLEAR:
                for (int i = 0; i < SLOTS; i++)
                    slot_live[i] = 1'b0;
            OP_TICK:
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_live[i]) begin
                        sum = {1'b0, slot_age[i]} + {1'b0, c.elapsed};
                        slot_age[i] = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
                        if (slot_age[i] >= slot_life[i]) begin
                            slot_live[i] = 1'b0;
                            if (i < MASK_W)
                                r.expired_mask[i] = 1'b1;
                        end
                    end
                end
            default: ;
        endcase
        for (int i = 0; i < SLOTS && i < MASK_W; i++)
            r.active_mask[i] = slot_live[i];
        return r;
    endfunction

    function automatic cmd_t make_cmd(logic [1:0] op, logic [TIME_W-1:0] dur,
                                      logic [TAG_W-1:0] tag, logic [TIME_W-1:0] step);
        cmd_t c;
        c.op          = op;
        c.duration    = dur;
        c.payload_tag = tag;
        c.elapsed     = step;
        return c;
    endfunction

    // Mostly short lifetimes so slots turn over; sometimes the extremes
    function automatic logic [TIME_W-1:0] pick_lifetime();
        case ($urandom_range(9))
            0:       return '0;
            1:       return TIME_MAX;
            2, 3:    return TIME_W'($urandom);
            default: return TIME_W'($urandom_range(400));
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_tick_step();
        case ($urandom_range(19))
            0:       return '0;
            1:       return TIME_MAX;
            2:       return TIME_W'($urandom);
            default: return TIME_W'($urandom_range(64));
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        return TIME_W'($urandom);
    endfunction

    function automatic logic [TAG_W-1:0] rand_tag();
        return TAG_W'($urandom);
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Driver: hand items to the block, predict each one as it is taken
    always @(posedge clk or negedge rst_n)
    begin
        logic take;
        logic quiet;
        logic next_start;
        cmd_t next_cmd;
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd   <= '0;
        end
        else
        begin
            take       = start && !busy;
            next_start = start;
            next_cmd   = cmd;
            if (take)
                expected_results.push_back(timer_table_step(cmd));
            if (!start || take)
            begin
                // hold back idles over a middle stretch of the run
                quiet = (items_issued >= 700) && (items_issued < 1100);
                if (pending_cmds.size() > 0 && (quiet || $urandom_range(99) >= 15))
                begin
                    next_start = 1'b1;
                    next_cmd   = pending_cmds.pop_front();
                    items_issued++;
                end
                else
                    next_start = 1'b0;
            end
            start <= next_start;
            cmd   <= next_cmd;
        end
    end

    // Monitor: compare each result with the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result: expected none, actual %h", $time, result);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("accepted", 32'(want.accepted), 32'(result.accepted));
                check_field("slot_index", 32'(want.slot_index), 32'(result.slot_index));
                check_field("active_mask", 32'(want.active_mask), 32'(result.active_mask));
                check_field("expired_mask", 32'(want.expired_mask),
                            32'(result.expired_mask));
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int queued;
        int burst;
        int pick;
        rst_n = 1'b0;

        // directed: zero lifetime, saturation, full table, unused op, clear
        pending_cmds.push_back(make_cmd(OP_PUSH, '0, '0, rand_time()));
        pending_cmds.push_back(make_cmd(OP_PUSH, TIME_MAX, '1, rand_time()));
        pending_cmds.push_back(make_cmd(OP_TICK, rand_time(), rand_tag(), '0));
        pending_cmds.push_back(make_cmd(OP_PUSH, 24'd5, 16'h5a5a, '1));
        pending_cmds.push_back(make_cmd(OP_TICK, '0, '0, 24'h800000));
        pending_cmds.push_back(make_cmd(OP_TICK, '1, '1, TIME_MAX));
        for (int i = 0; i < SLOTS; i++)
            pending_cmds.push_back(make_cmd(OP_PUSH, TIME_W'(100 * (i + 1)),
                                            rand_tag(), rand_time()));
        pending_cmds.push_back(make_cmd(OP_PUSH, 24'd7, 16'h1234, '0));
        pending_cmds.push_back(make_cmd(OP_UNUSED, rand_time(), rand_tag(), rand_time()));
        pending_cmds.push_back(make_cmd(OP_CLEAR, rand_time(), rand_tag(), rand_time()));

        // random: bursts of pushes and ticks so the table fills and drains
        queued = 0;
        while (queued < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                burst = $urandom_range(12, 1);
                for (int k = 0; k < burst; k++)
                    pending_cmds.push_back(make_cmd(OP_PUSH, pick_lifetime(),
                                                    rand_tag(), rand_time()));
            end
            else if (pick < 90)
            begin
                burst = $urandom_range(8, 1);
                for (int k = 0; k < burst; k++)
                    pending_cmds.push_back(make_cmd(OP_TICK, rand_time(),
                                                    rand_tag(), pick_tick_step()));
            end
            else if (pick < 96)
            begin
                burst = 1;
                pending_cmds.push_back(make_cmd(OP_CLEAR, rand_time(), rand_tag(),
                                                rand_time()));
            end
            else
            begin
                burst = 1;
                pending_cmds.push_back(make_cmd(OP_UNUSED, rand_time(), rand_tag(),
                                                rand_time()));
            end
            queued += burst;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // drain: every item taken, every result seen, then a quiet tail
        while (pending_cmds.size() > 0 || start)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb_one_shot_timer_slot_table: clean");
        else
            $display("tb_one_shot_timer_slot_table: errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #3_000_000;
        $display("tb_one_shot_timer_slot_table: errors");
        $finish;
    end

endmodule

@@ one_shot_timer_slot_table.f @@
src/osts_pkg.sv
src/osts_tick_unit.sv
src/one_shot_timer_slot_table.sv
tb/sv/tb_one_shot_timer_slot_table.sv
